[rtl/mer_pkg.sv]
// Shared types and constants for the midpoint ellipse rasterizer.
package mer_pkg;

  localparam int DW  = 48;   // decision / product width
  localparam int SW  = 32;   // step_dx / step_dy width
  localparam int CW  = 12;   // center coordinate width
  localparam int PCW = 13;   // point coordinate width

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_R1   = 2'd1,
    PH_R2   = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_MUL_AA,
    CS_MUL_BB,
    CS_MUL_BA,
    CS_INIT,
    CS_SETTLE,
    CS_ZERO,
    CS_SW_TT,
    CS_SW_BT,
    CS_SW_YY,
    CS_SW_AY,
    CS_SW_AB,
    CS_SW_FIN
  } ctl_state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_STEP,
    DP_MUL_AA,
    DP_MUL_BB,
    DP_MUL_BA,
    DP_INIT,
    DP_SW_TT,
    DP_SW_BT,
    DP_SW_YY,
    DP_SW_AY,
    DP_SW_AB,
    DP_SW_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   emit;
    logic   emit_zero;
  } cmd_t;

  typedef struct packed {
    phase_t phase;
    logic   switch_due;
    logic   final_set;
    logic   out_full;
  } stat_t;

endpackage

[rtl/mer_ctrl.sv]
// Sequencing state machine for the ellipse rasterizer.
module mer_ctrl import mer_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_op,
  output logic  in_stall,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  ctl_state_t state_r, state_nxt;
  logic       out_free;

  assign out_free = !stat.out_full || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_START) begin
            state_nxt = CS_MUL_AA;
          end else if (stat.phase != PH_IDLE) begin
            state_nxt = CS_SETTLE;
          end else begin
            state_nxt = CS_ZERO;
          end
        end
      end
      CS_MUL_AA: state_nxt = CS_MUL_BB;
      CS_MUL_BB: state_nxt = CS_MUL_BA;
      CS_MUL_BA: state_nxt = CS_INIT;
      CS_INIT:   state_nxt = CS_SETTLE;
      CS_SETTLE: begin
        if (stat.switch_due) begin
          state_nxt = CS_SW_TT;
        end else if (out_free) begin
          state_nxt = CS_IDLE;
        end
      end
      CS_ZERO: begin
        if (out_free) begin
          state_nxt = CS_IDLE;
        end
      end
      CS_SW_TT:  state_nxt = CS_SW_BT;
      CS_SW_BT:  state_nxt = CS_SW_YY;
      CS_SW_YY:  state_nxt = CS_SW_AY;
      CS_SW_AY:  state_nxt = CS_SW_AB;
      CS_SW_AB:  state_nxt = CS_SW_FIN;
      CS_SW_FIN: state_nxt = CS_SETTLE;
      default:   state_nxt = CS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.op        = DP_NOP;
    cmd.emit      = 1'b0;
    cmd.emit_zero = 1'b0;
    in_stall      = (state_r != CS_IDLE);
    unique case (state_r)
      CS_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_START) begin
            cmd.op = DP_LOAD;
          end else if (stat.phase != PH_IDLE) begin
            cmd.op = DP_STEP;
          end
        end
      end
      CS_MUL_AA: cmd.op = DP_MUL_AA;
      CS_MUL_BB: cmd.op = DP_MUL_BB;
      CS_MUL_BA: cmd.op = DP_MUL_BA;
      CS_INIT:   cmd.op = DP_INIT;
      CS_SETTLE: cmd.emit = !stat.switch_due && out_free;
      CS_ZERO:   cmd.emit_zero = out_free;
      CS_SW_TT:  cmd.op = DP_SW_TT;
      CS_SW_BT:  cmd.op = DP_SW_BT;
      CS_SW_YY:  cmd.op = DP_SW_YY;
      CS_SW_AY:  cmd.op = DP_SW_AY;
      CS_SW_AB:  cmd.op = DP_SW_AB;
      CS_SW_FIN: cmd.op = DP_SW_FIN;
      default:   cmd.op = DP_NOP;
    endcase
  end

endmodule

[rtl/mer_dpath.sv]
// Datapath: ellipse state registers, shared multiplier and result register.
module mer_dpath import mer_pkg::*; #(
  parameter int RADIUS_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  input  logic [RADIUS_BITS-1:0] in_radius_x,
  input  logic [RADIUS_BITS-1:0] in_radius_y,
  input  logic [CW-1:0]          in_center_x,
  input  logic [CW-1:0]          in_center_y,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic                   out_valid_res,
  output logic [PCW-1:0]         out_px_right,
  output logic [PCW-1:0]         out_px_left,
  output logic [PCW-1:0]         out_py_top,
  output logic [PCW-1:0]         out_py_bottom,
  output logic                   out_last
);

  localparam int RB  = RADIUS_BITS;
  localparam int SQW = 2 * RB;
  localparam int MW  = 2 * RB + 2;
  localparam int XW  = (2 * MW > DW) ? 2 * MW : DW;

  // signed divide by four, rounding toward zero
  function automatic logic [DW-1:0] div4(input logic [DW-1:0] v);
    logic [DW-1:0] q;
    q = {v[DW-1], v[DW-1], v[DW-1:2]};
    return q + DW'(v[DW-1] && (v[1:0] != 2'b00));
  endfunction

  phase_t          phase_r, phase_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic [RB-1:0]   rad_a_r, rad_a_nxt;
  logic [SQW-1:0]  a_sq_r, a_sq_nxt;
  logic [SQW-1:0]  b_sq_r, b_sq_nxt;
  logic [DW-1:0]   dec_r, dec_nxt;
  logic [SW-1:0]   dx_r, dx_nxt;
  logic [SW-1:0]   dy_r, dy_nxt;
  logic [RB-1:0]   cur_x_r, cur_x_nxt;
  logic [RB-1:0]   cur_y_r, cur_y_nxt;
  logic [CW-1:0]   org_x_r, org_x_nxt;
  logic [CW-1:0]   org_y_r, org_y_nxt;
  logic [DW-1:0]   mul_r;
  logic [DW-1:0]   acc_r, acc_nxt;

  logic            res_valid_r, res_valid_nxt;
  logic            res_last_r, res_last_nxt;
  logic [PCW-1:0]  px_r_r, px_r_nxt;
  logic [PCW-1:0]  px_l_r, px_l_nxt;
  logic [PCW-1:0]  py_t_r, py_t_nxt;
  logic [PCW-1:0]  py_b_r, py_b_nxt;

  logic [MW-1:0]   mul_a, mul_b;
  logic [XW-1:0]   prod;
  logic [SW-1:0]   twice_a2, twice_b2, dx_inc, dy_dec;
  logic [RB-1:0]   x_inc, y_dec, ym1;
  logic [RB:0]     t_odd;
  logic [DW-1:0]   mul_x4;
  logic [PCW-1:0]  ox13, oy13, cx13, cy13;
  logic            final_set;

  assign twice_a2  = SW'({a_sq_r, 1'b0});
  assign twice_b2  = SW'({b_sq_r, 1'b0});
  assign dx_inc    = dx_r + twice_b2;
  assign dy_dec    = dy_r - twice_a2;
  assign x_inc     = cur_x_r + RB'(1);
  assign y_dec     = cur_y_r - RB'(1);
  assign ym1       = (cur_y_r == '0) ? RB'(1) : y_dec;
  assign t_odd     = {cur_x_r, 1'b1};
  assign mul_x4    = {mul_r[DW-3:0], 2'b00};
  assign final_set = (phase_r == PH_R2) && (cur_y_r == '0);

  assign stat.phase      = phase_r;
  assign stat.switch_due = (phase_r == PH_R1) && !(dx_r < dy_r);
  assign stat.final_set  = final_set;
  assign stat.out_full   = out_valid_r;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      DP_MUL_AA: begin mul_a = MW'(rad_a_r);       mul_b = MW'(rad_a_r);       end
      DP_MUL_BB: begin mul_a = MW'(cur_y_r);       mul_b = MW'(cur_y_r);       end
      DP_MUL_BA: begin mul_a = MW'(cur_y_r);       mul_b = MW'(a_sq_r);        end
      DP_SW_TT:  begin mul_a = MW'(t_odd);         mul_b = MW'(t_odd);         end
      DP_SW_BT:  begin mul_a = MW'(b_sq_r);        mul_b = mul_r[MW-1:0];      end
      DP_SW_YY:  begin mul_a = MW'(ym1);           mul_b = MW'(ym1);           end
      DP_SW_AY:  begin mul_a = MW'(a_sq_r);        mul_b = mul_r[MW-1:0];      end
      DP_SW_AB:  begin mul_a = MW'(a_sq_r);        mul_b = MW'(b_sq_r);        end
      default:   begin mul_a = '0;                 mul_b = '0;                 end
    endcase
  end

  assign prod = XW'(mul_a) * XW'(mul_b);

  // ellipse state update
  always_comb begin
    phase_nxt = phase_r;
    rad_a_nxt = rad_a_r;
    a_sq_nxt  = a_sq_r;
    b_sq_nxt  = b_sq_r;
    dec_nxt   = dec_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    org_x_nxt = org_x_r;
    org_y_nxt = org_y_r;
    acc_nxt   = acc_r;
    case (cmd.op)
      DP_LOAD: begin
        rad_a_nxt = in_radius_x;
        cur_y_nxt = in_radius_y;
        cur_x_nxt = '0;
        dx_nxt    = '0;
        org_x_nxt = in_center_x;
        org_y_nxt = in_center_y;
        phase_nxt = PH_R1;
      end
      DP_MUL_BB: a_sq_nxt = mul_r[SQW-1:0];
      DP_MUL_BA: b_sq_nxt = mul_r[SQW-1:0];
      DP_INIT: begin
        dec_nxt = DW'(b_sq_r) - mul_r + DW'(a_sq_r >> 2);
        dy_nxt  = SW'({mul_r, 1'b0});
      end
      DP_STEP: begin
        if (phase_r == PH_R1) begin
          cur_x_nxt = x_inc;
          dx_nxt    = dx_inc;
          if (dec_r[DW-1]) begin
            dec_nxt = dec_r + DW'(b_sq_r) + DW'(dx_inc);
          end else begin
            cur_y_nxt = y_dec;
            dy_nxt    = dy_dec;
            dec_nxt   = dec_r + DW'(b_sq_r) + DW'(dx_inc) - DW'(dy_dec);
          end
        end else begin
          cur_y_nxt = y_dec;
          dy_nxt    = dy_dec;
          if (!dec_r[DW-1] && (dec_r != '0)) begin
            dec_nxt = dec_r + DW'(a_sq_r) - DW'(dy_dec);
          end else begin
            cur_x_nxt = x_inc;
            dx_nxt    = dx_inc;
            dec_nxt   = dec_r + DW'(a_sq_r) - DW'(dy_dec) + DW'(dx_inc);
          end
        end
      end
      DP_SW_YY:  acc_nxt = mul_r;
      DP_SW_AB:  acc_nxt = acc_r + mul_x4;
      DP_SW_FIN: begin
        dec_nxt   = div4(acc_r - mul_x4);
        phase_nxt = PH_R2;
      end
      default: ;
    endcase
    if (cmd.emit && final_set) begin
      phase_nxt = PH_IDLE;
    end
  end

  // result register
  assign ox13 = {org_x_r[CW-1], org_x_r};
  assign oy13 = {org_y_r[CW-1], org_y_r};
  assign cx13 = PCW'(cur_x_r);
  assign cy13 = PCW'(cur_y_r);

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    res_valid_nxt = res_valid_r;
    res_last_nxt  = res_last_r;
    px_r_nxt      = px_r_r;
    px_l_nxt      = px_l_r;
    py_t_nxt      = py_t_r;
    py_b_nxt      = py_b_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      res_valid_nxt = 1'b1;
      res_last_nxt  = final_set;
      px_r_nxt      = ox13 + cx13;
      px_l_nxt      = ox13 - cx13;
      py_t_nxt      = oy13 + cy13;
      py_b_nxt      = oy13 - cy13;
    end else if (cmd.emit_zero) begin
      out_valid_nxt = 1'b1;
      res_valid_nxt = 1'b0;
      res_last_nxt  = 1'b0;
      px_r_nxt      = '0;
      px_l_nxt      = '0;
      py_t_nxt      = '0;
      py_b_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_a_r     <= rad_a_nxt;
    a_sq_r      <= a_sq_nxt;
    b_sq_r      <= b_sq_nxt;
    dec_r       <= dec_nxt;
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    cur_x_r     <= cur_x_nxt;
    cur_y_r     <= cur_y_nxt;
    org_x_r     <= org_x_nxt;
    org_y_r     <= org_y_nxt;
    mul_r       <= prod[DW-1:0];
    acc_r       <= acc_nxt;
    res_valid_r <= res_valid_nxt;
    res_last_r  <= res_last_nxt;
    px_r_r      <= px_r_nxt;
    px_l_r      <= px_l_nxt;
    py_t_r      <= py_t_nxt;
    py_b_r      <= py_b_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = res_valid_r;
  assign out_last      = res_last_r;
  assign out_px_right  = px_r_r;
  assign out_px_left   = px_l_r;
  assign out_py_top    = py_t_r;
  assign out_py_bottom = py_b_r;

endmodule

[rtl/midpoint_ellipse_rasterizer.sv]
// Midpoint ellipse rasterizer top level: controller, datapath and checks.
// Step request: accept, then a settle state writes the result register once out_* is free.
// Start request: accept, three multiplier states, one to form the decision, then settle.
// Region-1 to region-2 switch: a settle pass that spots it, then five
// dependent products and a final combine on the one multiplier.
// A result appears on out_* the cycle after settle; a new request is taken while it waits.
// Reset (rst_n low, synchronous) idles the controller, drops out_valid and sets phase idle.
module midpoint_ellipse_rasterizer import mer_pkg::*; #(
  parameter int RADIUS_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_op,
  input  logic [RADIUS_BITS-1:0] in_radius_x,
  input  logic [RADIUS_BITS-1:0] in_radius_y,
  input  logic signed [CW-1:0]   in_center_x,
  input  logic signed [CW-1:0]   in_center_y,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_valid_res,
  output logic signed [PCW-1:0]  out_px_right,
  output logic signed [PCW-1:0]  out_px_left,
  output logic signed [PCW-1:0]  out_py_top,
  output logic signed [PCW-1:0]  out_py_bottom,
  output logic                   out_last
);

  // Controller only steers; all arithmetic state lives in the datapath.
  cmd_t  cmd;
  stat_t stat;

  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: one shared multiplier with a registered product. Start builds
  // a^2, b^2 and b*a^2; the region switch builds the exact region-2 start
  // value from b^2*(2x+1)^2, a^2*(y-1)^2 and a^2*b^2, then divides by four
  // rounding toward zero. Ordinary steps are single wide adds.
  mer_dpath #(
    .RADIUS_BITS (RADIUS_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_radius_x   (in_radius_x),
    .in_radius_y   (in_radius_y),
    .in_center_x   (in_center_x),
    .in_center_y   (in_center_y),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_valid_res (out_valid_res),
    .out_px_right  (out_px_right),
    .out_px_left   (out_px_left),
    .out_py_top    (out_py_top),
    .out_py_bottom (out_py_bottom),
    .out_last      (out_last)
  );

  // Final point set always belongs to a live ellipse.
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_valid_res)
    else $error("last flagged on an idle-step result");

  // Idle-step result carries all-zero fields.
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> (out_px_right == '0) && (out_px_left == '0) &&
      (out_py_top == '0) && (out_py_bottom == '0) && !out_last)
    else $error("idle-step result not cleared");

  // Emitting the final set returns the ellipse to idle.
  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && stat.final_set |=> stat.phase == PH_IDLE)
    else $error("phase not idle after final point set");

  // Load and step commands only issue on an accepted request.
  a_cmd_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_LOAD) || (cmd.op == DP_STEP) |-> in_valid && !in_stall)
    else $error("datapath command without accepted request");

endmodule

[test/mer_point_checker.sv]
// Point-set checker for the midpoint ellipse rasterizer: predicts each result and compares it.
module mer_point_checker import mer_pkg::*; #(
  parameter int RADIUS_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic                   in_op,
  input  logic [RADIUS_BITS-1:0] in_radius_x,
  input  logic [RADIUS_BITS-1:0] in_radius_y,
  input  logic signed [CW-1:0]   in_center_x,
  input  logic signed [CW-1:0]   in_center_y,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic                   out_valid_res,
  input  logic signed [PCW-1:0]  out_px_right,
  input  logic signed [PCW-1:0]  out_px_left,
  input  logic signed [PCW-1:0]  out_py_top,
  input  logic signed [PCW-1:0]  out_py_bottom,
  input  logic                   out_last,
  output int                     fail_count,
  output int                     pending,
  output int                     sets_checked,
  output int                     ellipses_done,
  output int                     region_switches
);

  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic                  valid_res;
    logic signed [PCW-1:0] px_right;
    logic signed [PCW-1:0] px_left;
    logic signed [PCW-1:0] py_top;
    logic signed [PCW-1:0] py_bottom;
    logic                  last;
  } point_set_t;

  point_set_t expected_sets[$];

  // walker state
  phase_t                 walk_phase;
  bit [63:0]              a2, b2;
  bit [DW-1:0]            err_term;
  bit [SW-1:0]            inc_x, inc_y;
  bit [RADIUS_BITS-1:0]   off_x, off_y;
  bit [CW-1:0]            cen_x, cen_y;

  // region 1 -> 2 handover and end-of-ellipse test
  function automatic logic close_region();
    bit [63:0]        t, y64, ym, v;
    logic signed [63:0] s;
    if (walk_phase == PH_R1 && !(inc_x < inc_y)) begin
      t = off_x;
      t = 2 * t + 1;
      y64 = off_y;
      ym = (y64 == 0) ? 64'd1 : (y64 - 1) * (y64 - 1);
      v = b2 * t * t + 4 * a2 * ym - 4 * a2 * b2;
      s = {{(64-DW){v[DW-1]}}, v[DW-1:0]};
      s = s / 4;
      err_term = s[DW-1:0];
      walk_phase = PH_R2;
      region_switches++;
    end
    if (walk_phase == PH_R2 && off_y == 0) begin
      walk_phase = PH_IDLE;
      ellipses_done++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic point_set_t mirror_points(input logic fin);
    point_set_t     p;
    logic [PCW-1:0] ox, oy;
    ox = {cen_x[CW-1], cen_x};
    oy = {cen_y[CW-1], cen_y};
    p.valid_res = 1'b1;
    p.px_right  = ox + off_x;
    p.px_left   = ox - off_x;
    p.py_top    = oy + off_y;
    p.py_bottom = oy - off_y;
    p.last      = fin;
    return p;
  endfunction

  function automatic point_set_t predict_points(input logic op,
                                                input logic [RADIUS_BITS-1:0] rx, ry,
                                                input logic [CW-1:0] cx, cy);
    bit [63:0]  a, b;
    logic       below, above;
    point_set_t idle_set;
    idle_set = '0;
    if (op == OP_START) begin
      a = rx;
      b = ry;
      a2 = a * a;
      b2 = b * b;
      err_term = b2 - b * a2 + a2 / 4;
      inc_x = '0;
      inc_y = 2 * a2 * b;
      off_x = '0;
      off_y = ry;
      cen_x = cx;
      cen_y = cy;
      walk_phase = PH_R1;
      return mirror_points(close_region());
    end
    case (walk_phase)
      PH_R1: begin
        below = err_term[DW-1];
        off_x = off_x + 1'b1;
        inc_x = inc_x + 2 * b2;
        if (!below) begin
          off_y = off_y - 1'b1;
          inc_y = inc_y - 2 * a2;
        end
        err_term = below ? err_term + b2 + inc_x : err_term + b2 + inc_x - inc_y;
        return mirror_points(close_region());
      end
      PH_R2: begin
        above = !err_term[DW-1] && err_term != 0;
        off_y = off_y - 1'b1;
        inc_y = inc_y - 2 * a2;
        if (!above) begin
          off_x = off_x + 1'b1;
          inc_x = inc_x + 2 * b2;
        end
        err_term = above ? err_term + a2 - inc_y : err_term + a2 - inc_y + inc_x;
        return mirror_points(close_region());
      end
      default: return idle_set;
    endcase
  endfunction

  task automatic check_field(input string name, input logic signed [15:0] want, got);
    if (got !== want) begin
      if (fail_count < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    point_set_t want;
    if (!rst_n) begin
      walk_phase = PH_IDLE;
      a2 = '0;
      b2 = '0;
      err_term = '0;
      inc_x = '0;
      inc_y = '0;
      off_x = '0;
      off_y = '0;
      cen_x = '0;
      cen_y = '0;
      expected_sets.delete();
      fail_count = 0;
      pending = 0;
      sets_checked = 0;
      ellipses_done = 0;
      region_switches = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_sets.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("%0t: result with none expected, got valid_res %0d (%0d,%0d,%0d,%0d) last %0d",
                     $time, out_valid_res, out_px_right, out_px_left, out_py_top,
                     out_py_bottom, out_last);
          fail_count++;
        end else begin
          want = expected_sets.pop_front();
          check_field("valid_res", want.valid_res, out_valid_res);
          check_field("px_right", want.px_right, out_px_right);
          check_field("px_left", want.px_left, out_px_left);
          check_field("py_top", want.py_top, out_py_top);
          check_field("py_bottom", want.py_bottom, out_py_bottom);
          check_field("last", want.last, out_last);
          sets_checked++;
        end
      end
      if (in_valid && !in_stall)
        expected_sets.push_back(predict_points(in_op, in_radius_x, in_radius_y,
                                               in_center_x, in_center_y));
      pending = expected_sets.size();
    end
  end

endmodule

[test/tb_midpoint_ellipse_rasterizer.sv]
// Testbench top for the midpoint ellipse rasterizer: request stimulus, pacing and verdict.
module tb_midpoint_ellipse_rasterizer import mer_pkg::*;;

  localparam int RADIUS_BITS     = 10;
  localparam int RADIUS_MAX      = (1 << RADIUS_BITS) - 1;
  localparam int RANDOM_REQUESTS = 1700;
  localparam int PHASE_REQUESTS  = 215;    // requests per pacing phase
  localparam int HOLD_TRIGGER    = 120;    // requests sent before the long output hold
  localparam int LONG_HOLD       = 400;    // cycles of solid output stall
  localparam int DRAIN_CYCLES    = 16;     // covers a start plus a region switch
  localparam int CYCLE_LIMIT     = 500000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_op = OP_START;
  logic [RADIUS_BITS-1:0] in_radius_x = '0;
  logic [RADIUS_BITS-1:0] in_radius_y = '0;
  logic signed [CW-1:0]   in_center_x = '0;
  logic signed [CW-1:0]   in_center_y = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   out_valid_res;
  logic signed [PCW-1:0]  out_px_right;
  logic signed [PCW-1:0]  out_px_left;
  logic signed [PCW-1:0]  out_py_top;
  logic signed [PCW-1:0]  out_py_bottom;
  logic                   out_last;

  int fail_count, pending, sets_checked, ellipses_done, region_switches;

  int requests_sent = 0;
  int idle_pct = 0;           // chance in a hundred that the sender idles a cycle
  int stall_pct = 0;          // chance in a hundred that the receiver stalls a cycle
  int hold_left = 0;
  bit long_hold_done = 1'b0;
  int cycles = 0;

  midpoint_ellipse_rasterizer #(.RADIUS_BITS(RADIUS_BITS)) uut (.*);

  // Watches both channels, predicts every point set and counts mismatches.
  mer_point_checker #(.RADIUS_BITS(RADIUS_BITS)) point_check (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Safety net: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("midpoint_ellipse_rasterizer test failed");
      $finish;
    end
  end

  // Receiver side. Once the sender is well under way, hold the output off for a long
  // stretch so that the result register fills and the block must stall its requests.
  always @(posedge clk) begin
    if (!long_hold_done && requests_sent >= HOLD_TRIGGER) begin
      long_hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic set_pacing(input int phase_no);
    case (phase_no)
      0: begin
        idle_pct = 0;
        stall_pct = 0;
      end
      1: begin
        idle_pct = 62;
        stall_pct = 0;
      end
      2: begin
        idle_pct = 0;
        stall_pct = 62;
      end
      default: begin
        idle_pct = 12;
        stall_pct = 12;
      end
    endcase
  endtask

  // Offer one request and wait until it is taken. Valid is only ever dropped by an idle
  // cycle, so back-to-back requests keep it high without a second assignment in the step.
  task automatic offer(input logic op, input int rx, ry, cx, cy);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_radius_x <= rx[RADIUS_BITS-1:0];
    in_radius_y <= ry[RADIUS_BITS-1:0];
    in_center_x <= cx[CW-1:0];
    in_center_y <= cy[CW-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  // Start request followed by a run of step requests; the step payload is don't-care
  // to the block, so it carries random bits.
  task automatic draw_ellipse(input int rx, ry, cx, cy, n_steps);
    offer(OP_START, rx, ry, cx, cy);
    repeat (n_steps)
      offer(OP_STEP, $urandom_range(0, RADIUS_MAX), $urandom_range(0, RADIUS_MAX),
            $urandom, $urandom);
  endtask

  initial begin
    int pick, rx, ry, n_steps, first_random;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: step while idle, zero radii, flat and tall extremes, corner centres,
    // and restarts that abandon an ellipse part-way.
    set_pacing(0);
    offer(OP_STEP, 0, 0, 0, 0);
    draw_ellipse(0, 0, 0, 0, 1);                    // finished at once, then an idle step
    draw_ellipse(0, 3, 2047, -2048, 4);             // no width: straight down x = 0
    draw_ellipse(5, 0, -2048, 2047, 0);             // no height: start set is the last
    draw_ellipse(RADIUS_MAX, RADIUS_MAX, 2047, 2047, 1);
    draw_ellipse(1, RADIUS_MAX, -2048, -2048, 3);   // early switch with large products
    draw_ellipse(RADIUS_MAX, 1, 0, 0, 3);
    draw_ellipse(3, 2, 5, -7, 6);                   // runs to the end, then idle steps

    // Random: mostly complete small ellipses, some abandoned, a few wide ones cut short,
    // and stray steps, cycling through the pacing phases.
    first_random = requests_sent;
    while (requests_sent - first_random < RANDOM_REQUESTS) begin
      set_pacing(((requests_sent - first_random) / PHASE_REQUESTS) % 4);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 3))
          offer(OP_STEP, $urandom_range(0, RADIUS_MAX), $urandom_range(0, RADIUS_MAX),
                $urandom, $urandom);
      end else begin
        if (pick < 75) begin
          rx = $urandom_range(0, 20);
          ry = $urandom_range(0, 20);
        end else if (pick < 92) begin
          rx = $urandom_range(0, 90);
          ry = $urandom_range(0, 90);
        end else begin
          rx = $urandom_range(0, RADIUS_MAX);
          ry = $urandom_range(0, RADIUS_MAX);
        end
        // a full walk never takes more than rx + ry steps
        if (pick >= 92)
          n_steps = $urandom_range(0, 30);
        else if ($urandom_range(0, 99) < 80)
          n_steps = rx + ry + 2;
        else
          n_steps = $urandom_range(0, rx + ry);
        draw_ellipse(rx, ry, $urandom, $urandom, n_steps);
      end
    end
    in_valid <= 1'b0;

    // Drain, then linger so a stray late result would still be caught.
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests sent over directed cases and four pacing phases, with a long hold",
             requests_sent);
    $display("%0d point sets compared, %0d ellipses walked to the end, %0d region handovers",
             sets_checked, ellipses_done, region_switches);
    if (fail_count == 0 && pending == 0)
      $display("midpoint_ellipse_rasterizer test passed");
    else
      $display("midpoint_ellipse_rasterizer test failed");
    $finish;
  end

endmodule

[sim.f]
rtl/mer_pkg.sv
rtl/mer_ctrl.sv
rtl/mer_dpath.sv
rtl/midpoint_ellipse_rasterizer.sv
test/mer_point_checker.sv
test/tb_midpoint_ellipse_rasterizer.sv
